### rtl/rgfr_pkg.sv
// rgfr_pkg: shared types for the RTU gap frame receiver.
// No dependencies; imported by rgfr_frame_store and rtu_gap_frame_receiver.
`timescale 1ns / 1ps

package rgfr_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POLL = 2'd1,
        ACT_READ = 2'd2,
        ACT_TAKE = 2'd3
    } t_action;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctl;

    localparam logic [30:0] GAP_RESET = 31'd1750;

endpackage

### rtl/rgfr_frame_store.sv
// rgfr_frame_store: two-bank frame byte memory, one write and one registered read port.
// Depends on rgfr_pkg.
`timescale 1ns / 1ps

module rgfr_frame_store
    import rgfr_pkg::*;
#(
    parameter int MAX_FRAME = 256,
    parameter int AW        = $clog2(2 * MAX_FRAME)
) (
    input  logic          i_clk,
    input  t_store_ctl    i_ctl,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    localparam int DEPTH = 2 * MAX_FRAME;

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/rtu_gap_frame_receiver.sv
// rtu_gap_frame_receiver: frames a serial byte stream at silent gaps.
// Depends on rgfr_pkg and rgfr_frame_store.
//
// Usage
//   Input channel (i_valid / o_stall): one transaction per action - push a
//   byte, poll the time, read a byte of the ready frame, or take that frame.
//   Push and poll carry a microsecond timestamp; an open frame silent for at
//   least the gap register is closed first: published, or dropped if overlong.
//   Output channel (o_valid / i_stall): one result transaction per input
//   transaction, in order: ready flag, length, read byte, take flag, counters.
//   Config channel (i_cfg_valid / o_cfg_ready): 31-bit gap time, always ready,
//   write only while idle.
// Timing
//   One transaction per cycle sustained while i_stall is low. o_valid rises
//   once the accepted transaction has passed the store-read stage and the
//   output register. Under i_stall one more transaction enters the
//   store-read stage, then o_stall rises until the output moves.
// Reset
//   Synchronous, active low: no open or ready frame, counters zero, gap time
//   1750 us. Frame store contents are left as they are.
`timescale 1ns / 1ps

module rtu_gap_frame_receiver
    import rgfr_pkg::*;
#(
    parameter int MAX_FRAME = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_action,
    input  logic [7:0]                       i_data_byte,
    input  logic [31:0]                      i_timestamp_us,
    input  logic [7:0]                       i_read_index,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [30:0]                      i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_frame_ready,
    output logic [$clog2(MAX_FRAME+1)-1:0]   o_frame_length,
    output logic [7:0]                       o_read_byte,
    output logic                             o_took_frame,
    output logic [31:0]                      o_frames_published,
    output logic [31:0]                      o_overlong_count,
    output logic [31:0]                      o_overrun_count
);

    localparam int CW   = $clog2(MAX_FRAME + 1);
    localparam int AW   = $clog2(2 * MAX_FRAME);
    localparam int CMPW = (CW > 8) ? CW : 8;

    // frame state
    logic          r_open_bank,  n_open_bank;
    logic [CW-1:0] r_open_count, n_open_count;
    logic          r_open_ovf,   n_open_ovf;
    logic [CW-1:0] r_held_count, n_held_count;
    logic          r_held,       n_held;
    logic [31:0]   r_last_time,  n_last_time;
    logic [31:0]   r_published,  n_published;
    logic [31:0]   r_overlong,   n_overlong;
    logic [31:0]   r_overrun,    n_overrun;
    logic [30:0]   r_gap_time;

    // store-read stage
    logic          r_p_valid;
    logic          r_p_ready;
    logic [CW-1:0] r_p_len;
    logic          r_p_rd_ok;
    logic          r_p_took;
    logic [31:0]   r_p_pub;
    logic [31:0]   r_p_ovl;
    logic [31:0]   r_p_ovr;

    // output stage
    logic          r_o_valid;
    logic          r_o_ready;
    logic [CW-1:0] r_o_len;
    logic [7:0]    r_o_byte;
    logic          r_o_took;
    logic [31:0]   r_o_pub;
    logic [31:0]   r_o_ovl;
    logic [31:0]   r_o_ovr;

    t_action       act;
    logic          accept;
    logic          p_adv;
    logic          o_take;
    logic [31:0]   diff;
    logic          gap_hit;
    logic [CW-1:0] cnt_mid;
    logic          ovf_mid;
    logic          bank_mid;
    logic          n_took;
    logic [CMPW-1:0] idx_ext;
    t_store_ctl    st_ctl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign act    = t_action'(i_action);
    assign o_take = r_o_valid && !i_stall;
    assign p_adv  = r_p_valid && (!r_o_valid || !i_stall);
    assign accept = i_valid && (!r_p_valid || p_adv);
    assign o_stall     = r_p_valid && !p_adv;
    assign o_cfg_ready = 1'b1;

    assign diff    = i_timestamp_us - r_last_time;
    assign idx_ext = CMPW'(i_read_index);

    always_comb begin
        gap_hit = ((act == ACT_PUSH) || (act == ACT_POLL)) && (r_open_count != '0)
                  && !diff[31] && (diff[30:0] >= r_gap_time);
        cnt_mid  = gap_hit ? '0 : r_open_count;
        ovf_mid  = gap_hit ? 1'b0 : r_open_ovf;
        bank_mid = r_open_bank ^ (gap_hit && !r_open_ovf);
        wr_addr  = bank_mid ? AW'(MAX_FRAME) + AW'(cnt_mid) : AW'(cnt_mid);
        rd_addr  = !r_open_bank ? AW'(MAX_FRAME) + AW'(idx_ext) : AW'(idx_ext);
    end

    always_comb begin
        n_open_bank  = r_open_bank;
        n_open_count = r_open_count;
        n_open_ovf   = r_open_ovf;
        n_held_count = r_held_count;
        n_held       = r_held;
        n_last_time  = r_last_time;
        n_published  = r_published;
        n_overlong   = r_overlong;
        n_overrun    = r_overrun;
        n_took       = 1'b0;
        st_ctl       = '0;
        if (accept) begin
            if (gap_hit) begin
                n_open_count = '0;
                n_open_ovf   = 1'b0;
                if (r_open_ovf) begin
                    n_overlong = r_overlong + 32'd1;
                end else begin
                    if (r_held) begin
                        n_overrun = r_overrun + 32'd1;
                    end
                    n_held_count = r_open_count;
                    n_held       = 1'b1;
                    n_published  = r_published + 32'd1;
                    n_open_bank  = ~r_open_bank;
                end
            end
            case (act)
                ACT_PUSH: begin
                    if (!ovf_mid) begin
                        if (cnt_mid >= CW'(MAX_FRAME)) begin
                            n_open_ovf = 1'b1;
                        end else begin
                            st_ctl.wr_en = 1'b1;
                            n_open_count = cnt_mid + CW'(1);
                        end
                    end
                    n_last_time = i_timestamp_us;
                end
                ACT_READ: begin
                    st_ctl.rd_en = r_held && (idx_ext < CMPW'(r_held_count))
                                   && (idx_ext < CMPW'(MAX_FRAME));
                end
                ACT_TAKE: begin
                    if (r_held) begin
                        n_held       = 1'b0;
                        n_held_count = '0;
                        n_took       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_bank  <= 1'b0;
            r_open_count <= '0;
            r_open_ovf   <= 1'b0;
            r_held_count <= '0;
            r_held       <= 1'b0;
            r_last_time  <= '0;
            r_published  <= '0;
            r_overlong   <= '0;
            r_overrun    <= '0;
            r_gap_time   <= GAP_RESET;
            r_p_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_open_bank  <= n_open_bank;
            r_open_count <= n_open_count;
            r_open_ovf   <= n_open_ovf;
            r_held_count <= n_held_count;
            r_held       <= n_held;
            r_last_time  <= n_last_time;
            r_published  <= n_published;
            r_overlong   <= n_overlong;
            r_overrun    <= n_overrun;
            if (i_cfg_valid) begin
                r_gap_time <= i_cfg_data;
            end
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (p_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_take) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_ready <= n_held;
            r_p_len   <= n_held_count;
            r_p_rd_ok <= st_ctl.rd_en;
            r_p_took  <= n_took;
            r_p_pub   <= n_published;
            r_p_ovl   <= n_overlong;
            r_p_ovr   <= n_overrun;
        end
        if (p_adv) begin
            r_o_ready <= r_p_ready;
            r_o_len   <= r_p_len;
            r_o_byte  <= r_p_rd_ok ? rd_data : 8'd0;
            r_o_took  <= r_p_took;
            r_o_pub   <= r_p_pub;
            r_o_ovl   <= r_p_ovl;
            r_o_ovr   <= r_p_ovr;
        end
    end

    rgfr_frame_store #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (st_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_valid            = r_o_valid;
    assign o_frame_ready      = r_o_ready;
    assign o_frame_length     = r_o_len;
    assign o_read_byte        = r_o_byte;
    assign o_took_frame       = r_o_took;
    assign o_frames_published = r_o_pub;
    assign o_overlong_count   = r_o_ovl;
    assign o_overrun_count    = r_o_ovr;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_p_valid && r_o_valid))
        else $error("input stalled with a free pipeline slot");

    a_held_len_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> (r_held_count == '0))
        else $error("held length non-zero without a ready frame");

    a_open_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_count <= CW'(MAX_FRAME))
        else $error("open frame count beyond maximum");

    a_overflow_at_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_ovf |-> (r_open_count == CW'(MAX_FRAME)))
        else $error("overflow flagged on a frame that is not full");

    a_publish_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_published != $past(r_published)) |->
            (r_published == $past(r_published) + 32'd1) && r_held)
        else $error("publish counter moved without a ready frame");
`endif

endmodule
